[sv/detection_score_smoother_macros.svh]
// ----------------------------------------------------------------------------
// detection score smoother assertion macros
// concurrent checks clocked on aclk and held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef DETECTION_SCORE_SMOOTHER_MACROS_SVH
`define DETECTION_SCORE_SMOOTHER_MACROS_SVH

// property that must hold at every edge out of reset
`define DSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// trigger at one edge, consequence at the next
`define DSS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) trig |=> cons) \
        else $error(msg);

`endif

[sv/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg
// shared types, register map and constants of the detection score smoother
// ----------------------------------------------------------------------------
package dss_pkg;

    // build defaults
    localparam int WINDOW_DEPTH_DEF  = 32;
    localparam int WARMUP_SCORES_DEF = 30;
    localparam int SCORE_BITS_DEF    = 16;

    // field widths
    localparam int WLEN_W    = 6;
    localparam int VAL_W     = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // window length limits and register reset values
    localparam int WLEN_MAX   = 32;
    localparam int WLEN_RST   = 5;
    localparam logic [VAL_W-1:0] CUTOFF_RST = 16'd63570;
    localparam logic [VAL_W-1:0] REFR_RST   = 16'd1500;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS = 7;

    // register index (word address)
    typedef enum logic [2:0] {
        REG_WINDOW_LENGTH = 3'd0,
        REG_CUTOFF        = 3'd1,
        REG_REFRACTORY    = 3'd2,
        REG_DETECT_ENABLE = 3'd3,
        REG_TEST_MODE     = 3'd4
    } reg_idx_t;

    // input word kinds
    typedef enum logic [1:0] {
        MODE_SCORE   = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WLEN_W-1:0] window_length;
        logic [VAL_W-1:0]  mean_threshold;
        logic [VAL_W-1:0]  quiet_period;
        logic              detect_enable;
        logic              test_mode;
    } cfg_t;

endpackage

[sv/dss_cfg.sv]
// ----------------------------------------------------------------------------
// dss_cfg
// apb register file; window length writes saturate and request a window clear
// ----------------------------------------------------------------------------
module dss_cfg #(
    parameter int WINDOW_DEPTH = dss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dss_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dss_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dss_pkg::APB_DATA_W-1:0]  prdata,
    output dss_pkg::cfg_t                   cfg_o,
    output logic                            win_clear_o
);
    import dss_pkg::*;

    localparam int WIN_CAP  = (WINDOW_DEPTH < WLEN_MAX) ? WINDOW_DEPTH : WLEN_MAX;
    localparam int WLEN_INI = (WLEN_RST > WIN_CAP) ? WIN_CAP : WLEN_RST;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              wr_fire;
    reg_idx_t          idx;
    logic [WLEN_W-1:0] wlen_lim;

    assign wr_fire = psel & penable & pwrite;
    assign idx     = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    // saturate a written window length into 1..cap
    always_comb begin
        wlen_lim = pwdata[WLEN_W-1:0];
        if (wlen_lim == '0) begin
            wlen_lim = WLEN_W'(1);
        end else if (int'(wlen_lim) > WIN_CAP) begin
            wlen_lim = WLEN_W'(WIN_CAP);
        end
    end

    // register writes
    always_comb begin
        cfg_next    = cfg_reg;
        win_clear_o = 1'b0;
        if (wr_fire) begin
            case (idx)
                REG_WINDOW_LENGTH: begin
                    cfg_next.window_length = wlen_lim;
                    win_clear_o            = 1'b1;
                end
                REG_CUTOFF:        cfg_next.mean_threshold = pwdata[VAL_W-1:0];
                REG_REFRACTORY:    cfg_next.quiet_period   = pwdata[VAL_W-1:0];
                REG_DETECT_ENABLE: cfg_next.detect_enable  = pwdata[0];
                REG_TEST_MODE:     cfg_next.test_mode      = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= WLEN_W'(WLEN_INI);
            cfg_reg.mean_threshold <= CUTOFF_RST;
            cfg_reg.quiet_period   <= REFR_RST;
            cfg_reg.detect_enable  <= 1'b1;
            cfg_reg.test_mode      <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(cfg_reg.window_length);
            REG_CUTOFF:        prdata = APB_DATA_W'(cfg_reg.mean_threshold);
            REG_REFRACTORY:    prdata = APB_DATA_W'(cfg_reg.quiet_period);
            REG_DETECT_ENABLE: prdata = APB_DATA_W'(cfg_reg.detect_enable);
            REG_TEST_MODE:     prdata = APB_DATA_W'(cfg_reg.test_mode);
            default:           prdata = '0;
        endcase
    end

    assign cfg_o = cfg_reg;

endmodule

[sv/dss_ring.sv]
// ----------------------------------------------------------------------------
// dss_ring
// score ring memory, one write and one registered read port, with a valid
// bit per entry so a whole-window clear happens at once
// ----------------------------------------------------------------------------
module dss_ring #(
    parameter int DEPTH  = dss_pkg::WINDOW_DEPTH_DEF,
    parameter int DATA_W = dss_pkg::SCORE_BITS_DEF,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear_i,
    input  logic              rd_en_i,
    input  logic [ADDR_W-1:0] rd_addr_i,
    output logic [DATA_W-1:0] rd_data_o,
    input  logic              wr_en_i,
    input  logic [ADDR_W-1:0] wr_addr_i,
    input  logic [DATA_W-1:0] wr_data_i
);
    import dss_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    // storage and read port
    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            mem[wr_addr_i] <= wr_data_i;
        end
        if (rd_en_i) begin
            rd_data_reg <= mem[rd_addr_i];
        end
    end

    // entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (rd_en_i) begin
                rd_valid_reg <= valid_reg[rd_addr_i];
            end
            if (clear_i) begin
                valid_reg <= '0;
            end else if (wr_en_i) begin
                valid_reg[wr_addr_i] <= 1'b1;
            end
        end
    end

    assign rd_data_o = rd_valid_reg ? rd_data_reg : '0;

endmodule

[sv/dss_divider.sv]
// ----------------------------------------------------------------------------
// dss_divider
// restoring divider for window sum / window length, several quotient bits
// per cycle, done pulses in the cycle after the last step
// ----------------------------------------------------------------------------
module dss_divider #(
    parameter int SUM_W = 21
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start_i,
    input  logic [SUM_W-1:0]           dividend_i,
    input  logic [dss_pkg::WLEN_W-1:0] divisor_i,
    output logic                       done_o,
    output logic [SUM_W-1:0]           quotient_o
);
    import dss_pkg::*;

    localparam int CYCLES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W  = CYCLES * DIV_STEPS;
    localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

    logic [PAD_W-1:0]  num_reg;
    logic [WLEN_W-1:0] rem_reg;
    logic [WLEN_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PAD_W-1:0]  num_next;
    logic [WLEN_W-1:0] rem_next;

    // one cycle worth of shift-and-subtract steps
    always_comb begin
        logic [WLEN_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial    = {rem_next, num_next[PAD_W-1]};
            num_next = {num_next[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                trial       = trial - {1'b0, div_reg};
                num_next[0] = 1'b1;
            end
            rem_next = trial[WLEN_W-1:0];
        end
    end

    // sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(CYCLES - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operands and partial quotient
    always_ff @(posedge aclk) begin
        if (start_i) begin
            num_reg <= PAD_W'(dividend_i);
            rem_reg <= '0;
            div_reg <= divisor_i;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done_o     = done_reg;
    assign quotient_o = num_reg[SUM_W-1:0];

endmodule

[sv/detection_score_smoother.sv]
// ----------------------------------------------------------------------------
// detection_score_smoother
// windowed mean of detection scores with threshold, warmup and refractory
// ----------------------------------------------------------------------------
// Usage: words enter on s_axis; tuser[1:0] gives the kind (score, 1 ms tick,
// restart) and tdata[15:0] the score. Only score words give a result word on
// m_axis: tdata holds mean, peak and hit count, tuser the detected, test hit
// and warmed-up flags. Ticks and restarts complete in the cycle of accept.
// From accept to result a score word passes a ring memory read, the
// read-modify-write of the ring and running sum, the iterative divider
// (7 quotient bits per cycle) and the decision step; the window sum is 21
// bits wide by default. One score is in flight at a time, and tready
// returns in the same cycle as the result is loaded.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, the following score waits in the decision
// step until the output register frees up.
// Reset (aresetn low, synchronous) restores register defaults and clears
// the window, counters and countdown at once; no clearing pass is needed.
// Configuration goes through the APB port while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "detection_score_smoother_macros.svh"

module detection_score_smoother #(
    parameter int WINDOW_DEPTH  = dss_pkg::WINDOW_DEPTH_DEF,
    parameter int WARMUP_SCORES = dss_pkg::WARMUP_SCORES_DEF,
    parameter int SCORE_BITS    = dss_pkg::SCORE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [15:0] score
    input  logic [1:0]                     s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata,  // [15:0] mean_score,
                                                          // [31:16] peak_mean,
                                                          // [47:32] hit_count
    output logic [2:0]                     m_axis_tuser,  // [0] detected,
                                                          // [1] is_test_hit,
                                                          // [2] warmed_up
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dss_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dss_pkg::*;

    localparam int SW     = (SCORE_BITS < VAL_W) ? SCORE_BITS : VAL_W;
    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = SW + $clog2(WINDOW_DEPTH);
    localparam int CMP_W  = (IDX_W + 1 > WLEN_W) ? IDX_W + 1 : WLEN_W;
    localparam int WARM_W = (WARMUP_SCORES > 0) ? $clog2(WARMUP_SCORES + 1) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DECIDE
    } state_t;

    cfg_t             cfg_q;
    logic             cfg_clear;
    logic             s_fire;
    mode_t            mode;

    // control state
    state_t           state_reg, state_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] wi_reg, wi_next;
    logic [WARM_W-1:0] warm_cnt_reg, warm_cnt_next;
    logic [VAL_W-1:0] quiet_reg, quiet_next;
    logic [VAL_W-1:0] peak_reg, peak_next;
    logic [VAL_W-1:0] hits_reg, hits_next;
    logic             m_valid_reg, m_valid_next;

    // payload
    logic [SW-1:0]    score_reg, score_next;
    logic [VAL_W-1:0] out_mean_reg, out_mean_next;
    logic [VAL_W-1:0] out_peak_reg, out_peak_next;
    logic [VAL_W-1:0] out_hits_reg, out_hits_next;
    logic             out_det_reg, out_det_next;
    logic             out_thit_reg, out_thit_next;
    logic             out_warm_reg, out_warm_next;

    // datapath
    logic             ring_rd_en, ring_wr_en, ring_clear;
    logic [SW-1:0]    ring_rd_data;
    logic [SUM_W-1:0] sum_upd;
    logic             div_start, div_done;
    logic [SUM_W-1:0] quotient;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] peak_upd;
    logic [WARM_W-1:0] warm_cnt_upd;
    logic             warm;
    logic             det;
    logic             decide_fire;

    // register file
    dss_cfg #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .cfg_o       (cfg_q),
        .win_clear_o (cfg_clear)
    );

    // score ring
    dss_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .DATA_W (SW),
        .ADDR_W (IDX_W)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear_i   (ring_clear),
        .rd_en_i   (ring_rd_en),
        .rd_addr_i (wi_reg),
        .rd_data_o (ring_rd_data),
        .wr_en_i   (ring_wr_en),
        .wr_addr_i (wi_reg),
        .wr_data_i (score_reg)
    );

    // mean divider
    dss_divider #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (sum_upd),
        .divisor_i  (cfg_q.window_length),
        .done_o     (div_done),
        .quotient_o (quotient)
    );

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign mode          = mode_t'(s_axis_tuser);

    // running sum with the oldest score swapped for the new one
    assign sum_upd = sum_reg - SUM_W'(ring_rd_data) + SUM_W'(score_reg);

    // decision terms
    assign mean         = VAL_W'(quotient);
    assign peak_upd     = (cfg_q.test_mode && mean > peak_reg) ? mean : peak_reg;
    assign warm_cnt_upd = (int'(warm_cnt_reg) < WARMUP_SCORES)
                        ? warm_cnt_reg + WARM_W'(1) : warm_cnt_reg;
    assign warm         = int'(warm_cnt_upd) >= WARMUP_SCORES;
    assign det          = warm && (cfg_q.detect_enable || cfg_q.test_mode)
                        && mean >= cfg_q.mean_threshold && quiet_reg == '0;
    assign decide_fire  = (state_reg == ST_DECIDE) && (!m_valid_reg || m_axis_tready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        wi_next       = wi_reg;
        warm_cnt_next = warm_cnt_reg;
        quiet_next    = quiet_reg;
        peak_next     = peak_reg;
        hits_next     = hits_reg;
        m_valid_next  = m_valid_reg;
        score_next    = score_reg;
        out_mean_next = out_mean_reg;
        out_peak_next = out_peak_reg;
        out_hits_next = out_hits_reg;
        out_det_next  = out_det_reg;
        out_thit_next = out_thit_reg;
        out_warm_next = out_warm_reg;
        ring_rd_en    = 1'b0;
        ring_wr_en    = 1'b0;
        ring_clear    = cfg_clear;
        div_start     = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (mode)
                        MODE_SCORE: begin
                            ring_rd_en = 1'b1;
                            score_next = s_axis_tdata[SW-1:0];
                            state_next = ST_UPDATE;
                        end
                        MODE_TICK: begin
                            if (quiet_reg != '0) begin
                                quiet_next = quiet_reg - VAL_W'(1);
                            end
                        end
                        MODE_RESTART: begin
                            ring_clear    = 1'b1;
                            sum_next      = '0;
                            wi_next       = '0;
                            warm_cnt_next = '0;
                            peak_next     = '0;
                            hits_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_UPDATE: begin
                ring_wr_en = 1'b1;
                sum_next   = sum_upd;
                div_start  = 1'b1;
                if (CMP_W'(wi_reg) + CMP_W'(1) == CMP_W'(cfg_q.window_length)) begin
                    wi_next = '0;
                end else begin
                    wi_next = wi_reg + IDX_W'(1);
                end
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (decide_fire) begin
                    peak_next     = peak_upd;
                    warm_cnt_next = warm_cnt_upd;
                    if (det) begin
                        quiet_next = cfg_q.quiet_period;
                        sum_next   = '0;
                        ring_clear = 1'b1;
                        if (cfg_q.test_mode && hits_reg != '1) begin
                            hits_next = hits_reg + VAL_W'(1);
                        end
                    end
                    m_valid_next  = 1'b1;
                    out_mean_next = mean;
                    out_peak_next = peak_upd;
                    out_hits_next = (det && cfg_q.test_mode && hits_reg != '1)
                                  ? hits_reg + VAL_W'(1) : hits_reg;
                    out_det_next  = det;
                    out_thit_next = det && cfg_q.test_mode;
                    out_warm_next = warm;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // window length write empties the window
        if (cfg_clear) begin
            sum_next = '0;
            wi_next  = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            wi_reg       <= '0;
            warm_cnt_reg <= '0;
            quiet_reg    <= '0;
            peak_reg     <= '0;
            hits_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            wi_reg       <= wi_next;
            warm_cnt_reg <= warm_cnt_next;
            quiet_reg    <= quiet_next;
            peak_reg     <= peak_next;
            hits_reg     <= hits_next;
            m_valid_reg  <= m_valid_next;
        end
        score_reg    <= score_next;
        out_mean_reg <= out_mean_next;
        out_peak_reg <= out_peak_next;
        out_hits_reg <= out_hits_next;
        out_det_reg  <= out_det_next;
        out_thit_reg <= out_thit_next;
        out_warm_reg <= out_warm_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_hits_reg, out_peak_reg, out_mean_reg};
    assign m_axis_tuser  = {out_warm_reg, out_thit_reg, out_det_reg};

    // checks
    `DSS_ASSERT(a_wi_in_window, CMP_W'(wi_reg) < CMP_W'(cfg_q.window_length), "ring pointer outside window")
    `DSS_ASSERT(a_result_from_decide, $rose(m_axis_tvalid) |-> $past(state_reg == ST_DECIDE), "result word without a decision")
    `DSS_ASSERT_NEXT(a_refractory_load, decide_fire && det, quiet_reg == $past(cfg_q.quiet_period), "countdown not reloaded")

endmodule

[dv/detection_score_smoother_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection score smoother checker
// watches the input, result and register ports, keeps its own model of the
// windowed mean, warmup, hold-off and test-mode counters, and compares every
// result word field by field with the oldest prediction still waiting
// ----------------------------------------------------------------------------
module detection_score_smoother_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] score
    input  logic [1:0]                     s_axis_tuser,   // [1:0] mode
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [47:0]                    m_axis_tdata,   // [15:0] mean_score,
                                                           // [31:16] peak_mean,
                                                           // [47:32] hit_count
    input  logic [2:0]                     m_axis_tuser,   // [0] detected,
                                                           // [1] is_test_hit,
                                                           // [2] warmed_up
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dss_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int unsigned                    fail_count,
    output int unsigned                    results_due
);
    import dss_pkg::*;

    localparam int RING_DEPTH  = WINDOW_DEPTH_DEF;
    localparam int WARMUP_LEN  = WARMUP_SCORES_DEF;
    localparam int PRINT_LIMIT = 40;

    // one predicted result word
    typedef struct packed {
        logic [VAL_W-1:0] mean;
        logic             detected;
        logic             test_hit;
        logic [VAL_W-1:0] peak;
        logic [VAL_W-1:0] hits;
        logic             warmed_up;
    } score_verdict_t;

    // register copy
    logic [WLEN_W-1:0] win_len;
    logic [VAL_W-1:0]  cutoff;
    logic [VAL_W-1:0]  holdoff_reload;
    logic              enable;
    logic              test_on;

    // streaming state
    logic [VAL_W-1:0]  ring [RING_DEPTH];
    logic [4:0]        slot;
    logic [20:0]       run_sum;
    int unsigned       scores_seen;
    logic [VAL_W-1:0]  holdoff_ms;
    logic [VAL_W-1:0]  peak_mean;
    logic [VAL_W-1:0]  test_hits;

    score_verdict_t    pending_verdicts [$];

    // zero the stored scores and their sum, leaving the write slot alone
    function automatic void empty_ring();
        foreach (ring[i]) ring[i] = '0;
        run_sum = '0;
    endfunction

    // one score through the window, threshold and hold-off
    function automatic score_verdict_t smooth_score(input logic [VAL_W-1:0] score);
        score_verdict_t v;
        logic [4:0]     at;
        v = '0;
        at = 5'(32'(slot) % 32'(win_len));
        run_sum = run_sum - ring[at] + score;
        ring[at] = score;
        slot = 5'((32'(at) + 1) % 32'(win_len));
        v.mean = 16'(run_sum / win_len);

        if (test_on && v.mean > peak_mean) peak_mean = v.mean;
        if (scores_seen < WARMUP_LEN) scores_seen++;
        v.warmed_up = (scores_seen >= WARMUP_LEN);

        // decision, held back in warmup, during the hold-off, below the cutoff and when both enables are off
        if (v.warmed_up && (enable || test_on) && v.mean >= cutoff && holdoff_ms == 0) begin
            v.detected = 1'b1;
            holdoff_ms = holdoff_reload;
            empty_ring();
            if (test_on) begin
                v.test_hit = 1'b1;
                if (test_hits != 16'hFFFF) test_hits++;
            end
        end
        v.peak = peak_mean;
        v.hits = test_hits;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        score_verdict_t want;
        if (!aresetn) begin
            win_len        = 6'(WLEN_RST);
            cutoff         = CUTOFF_RST;
            holdoff_reload = REFR_RST;
            enable         = 1'b1;
            test_on        = 1'b0;
            empty_ring();
            slot        = '0;
            scores_seen = 0;
            holdoff_ms  = '0;
            peak_mean   = '0;
            test_hits   = '0;
            pending_verdicts.delete();
            fail_count  = 0;
        end else begin
            // result word against the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result word with none expected, mean",
                                    m_axis_tdata[15:0], '0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_axis_tdata[15:0] !== want.mean)
                        report_mismatch("mean_score", m_axis_tdata[15:0], want.mean);
                    if (m_axis_tuser[0] !== want.detected)
                        report_mismatch("detected", 16'(m_axis_tuser[0]), 16'(want.detected));
                    if (m_axis_tuser[1] !== want.test_hit)
                        report_mismatch("is_test_hit", 16'(m_axis_tuser[1]), 16'(want.test_hit));
                    if (m_axis_tdata[31:16] !== want.peak)
                        report_mismatch("peak_mean", m_axis_tdata[31:16], want.peak);
                    if (m_axis_tdata[47:32] !== want.hits)
                        report_mismatch("hit_count", m_axis_tdata[47:32], want.hits);
                    if (m_axis_tuser[2] !== want.warmed_up)
                        report_mismatch("warmed_up", 16'(m_axis_tuser[2]), 16'(want.warmed_up));
                end
            end

            // register writes, bits above each width ignored
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_WINDOW_LENGTH: begin
                        win_len = (pwdata[5:0] == 0) ? 6'd1 :
                                  (pwdata[5:0] > WLEN_MAX) ? 6'(WLEN_MAX) : pwdata[5:0];
                        empty_ring();
                        slot = '0;
                    end
                    REG_CUTOFF:        cutoff = pwdata[15:0];
                    REG_REFRACTORY:    holdoff_reload = pwdata[15:0];
                    REG_DETECT_ENABLE: enable = pwdata[0];
                    REG_TEST_MODE:     test_on = pwdata[0];
                    default: ;
                endcase
            end

            // input word
            if (s_axis_tvalid && s_axis_tready) begin
                case (mode_t'(s_axis_tuser))
                    MODE_SCORE: pending_verdicts.push_back(smooth_score(s_axis_tdata));
                    MODE_TICK: begin
                        if (holdoff_ms != 0) holdoff_ms--;
                    end
                    MODE_RESTART: begin
                        empty_ring();
                        slot        = '0;
                        scores_seen = 0;
                        peak_mean   = '0;
                        test_hits   = '0;
                    end
                    default: ;
                endcase
            end
        end
        results_due <= pending_verdicts.size();
    end

endmodule

[dv/tb_detection_score_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection score smoother testbench
// drives score, tick, restart and unused-kind words in bursts through a run of register
// settings, stalls the result side on changing patterns, and takes the
// verdict from the checker's failure count
// ----------------------------------------------------------------------------
module tb_detection_score_smoother;
    import dss_pkg::*;

    localparam int         PHASES          = 8;
    localparam int         WORDS_PER_PHASE = 250;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         CYCLE_LIMIT     = 600000;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_MOSTLY
    } ready_style_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // [15:0] score
    logic [1:0]            s_axis_tuser;   // [1:0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;   // [15:0] mean_score, [31:16] peak_mean,
                                           // [47:32] hit_count
    logic [2:0]            m_axis_tuser;   // [0] detected, [1] is_test_hit,
                                           // [2] warmed_up
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned           fail_count;
    int unsigned           results_due;

    ready_style_t          ready_style = READY_ALWAYS;
    int unsigned           stall_left  = 0;

    detection_score_smoother i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    detection_score_smoother_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result side stalls, with the pattern picked at random and redrawn whenever its stall counter runs out
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            stall_left  = $urandom_range(8, 64);
        end
        stall_left = stall_left - 1;
        case (ready_style)
            READY_ALWAYS: m_axis_tready = 1'b1;
            READY_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
            READY_SPARSE: m_axis_tready = (stall_left % 16 == 0);
            default:      m_axis_tready = ($urandom_range(0, 3) != 0);
        endcase
    end

    // one word, held until accepted; returns on the following falling edge
    task automatic send_word(input logic [1:0] kind, input logic [15:0] score);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = score;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // setup then access cycle
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop sending, let every expected word arrive, then let the block drain
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int unsigned       counted;
        int unsigned       burst_left;
        int unsigned       gap;
        int unsigned       pick;
        logic              no_gaps;
        logic [WLEN_W-1:0] wraw;
        logic [15:0]       cut;
        logic [15:0]       refr;
        logic [15:0]       score_floor;
        logic [15:0]       score;

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words under the reset settings, window of five
        repeat (6) send_word(MODE_SCORE, 16'hFFFF);
        send_word(MODE_SCORE, 16'h0000);
        send_word(MODE_SCORE, 16'hAAAA);
        send_word(MODE_SCORE, 16'h5555);
        send_word(MODE_SCORE, 16'h0001);
        send_word(MODE_TICK, 16'hFFFF);
        send_word(MODE_UNUSED, 16'h1234);
        send_word(MODE_SCORE, 16'h8000);
        send_word(MODE_RESTART, 16'h0000);
        send_word(MODE_SCORE, 16'hFFFF);
        send_word(MODE_TICK, 16'h0000);
        send_word(MODE_SCORE, 16'h7FFF);
        settle();

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       wraw = 6'd0;
                1:       wraw = 6'd63;
                2:       wraw = 6'd32;
                3:       wraw = 6'd1;
                4:       wraw = 6'd33;
                default: wraw = 6'($urandom_range(2, 31));
            endcase
            if (p == 0)
                cut = 16'h0000;
            else if (p == 1)
                cut = 16'hFFFF;
            else
                cut = 16'($urandom_range(30000, 65535));
            // no hold-off first, the longest last so it cannot starve later phases
            if (p == 0)
                refr = 16'h0000;
            else if (p == PHASES - 1)
                refr = 16'hFFFF;
            else
                refr = 16'($urandom_range(1, 12));
            score_floor = (cut > 3000) ? cut - 16'd3000 : 16'd0;
            no_gaps     = (p == 2 || p == 5);

            write_reg(REG_WINDOW_LENGTH, {26'($urandom()), wraw});
            write_reg(REG_CUTOFF, {16'($urandom()), cut});
            write_reg(REG_REFRACTORY, {16'($urandom()), refr});
            write_reg(REG_DETECT_ENABLE, {31'($urandom()), 1'(p % 4 != 1)});
            write_reg(REG_TEST_MODE, {31'($urandom()), 1'(p % 4 >= 2)});

            counted    = 0;
            burst_left = 0;
            while (counted < WORDS_PER_PHASE) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = no_gaps ? 0 : $urandom_range(1, 10);
                    if (gap != 0) begin
                        s_axis_tvalid = 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                end
                burst_left--;

                // mostly scores near or above the cutoff, with ticks to run down
                // the hold-off and the odd restart to start a fresh warmup
                pick = $urandom_range(0, 999);
                if (pick < 8) begin
                    send_word(MODE_RESTART, 16'($urandom()));
                    counted++;
                end else if (pick < 25) begin
                    send_word(MODE_UNUSED, 16'($urandom()));
                end else if (pick < 275) begin
                    send_word(MODE_TICK, 16'($urandom()));
                    counted++;
                end else begin
                    if (pick < 525)
                        score = 16'hFFFF;
                    else if (pick < 900)
                        score = 16'($urandom_range(score_floor, 65535));
                    else
                        score = 16'($urandom());
                    send_word(MODE_SCORE, score);
                    counted++;
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
